// ----- rtl/ptt_pkg.sv -----
// Shared types and constants for the pan/tilt tracking controller.
package ptt_pkg;

	localparam int ANG_W  = 24;
	localparam int ACC_W  = 28;
	localparam int ERR_W  = 11;
	localparam int PA_W   = 29;
	localparam int PB_W   = 25;
	localparam int PROD_W = PA_W + PB_W;
	localparam int SUM_W  = 56;
	localparam int POS_W  = 34;

	localparam logic [ANG_W-1:0] ANG_MAX  = 24'd11796480;
	localparam logic [ANG_W-1:0] ANG_FLIP = 24'd5898240;
	localparam logic signed [PA_W-1:0] ACC_LIM = 29'sd65536000;
	localparam logic signed [PB_W-1:0] K_03 = 25'sd19661;
	localparam logic signed [PB_W-1:0] K_09 = 25'sd58982;

	localparam logic [23:0] RST_GAIN_P     = 24'd218104;
	localparam logic [23:0] RST_GAIN_I     = 24'd1678;
	localparam logic [23:0] RST_GAIN_D     = 24'd587203;
	localparam logic [7:0]  RST_DEAD_BAND  = 8'd5;
	localparam logic [15:0] RST_LOST_LIMIT = 16'd30;
	localparam logic [15:0] RST_HOME_GAIN  = 16'd6554;
	localparam logic [23:0] RST_HOME_PAN   = 24'd5898240;
	localparam logic [23:0] RST_HOME_TILT  = 24'd5898240;

	localparam logic [1:0] MODE_TRACK = 2'd0;
	localparam logic [1:0] MODE_HOLD  = 2'd1;
	localparam logic [1:0] MODE_HOME  = 2'd2;

	localparam logic [1:0] OP_ACC = 2'd0;
	localparam logic [1:0] OP_P   = 2'd1;
	localparam logic [1:0] OP_I   = 2'd2;
	localparam logic [1:0] OP_D   = 2'd3;

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_DEAD_BAND,
		REG_LOST_LIMIT,
		REG_HOME_GAIN,
		REG_HOME_PAN,
		REG_HOME_TILT
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] gain_p;
		logic [23:0] gain_i;
		logic [23:0] gain_d;
		logic [7:0]  dead_band;
		logic [15:0] lost_limit;
		logic [15:0] home_gain;
		logic [23:0] home_pan;
		logic [23:0] home_tilt;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PID,
		ST_HOME,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/ptt_cfg.sv -----
// Configuration register file with reset defaults.
module ptt_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_addr,
	input  logic [23:0]        cfg_wdata,
	output ptt_pkg::cfg_t      cfg
);
	import ptt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= RST_GAIN_P;
			cfg_q.gain_i     <= RST_GAIN_I;
			cfg_q.gain_d     <= RST_GAIN_D;
			cfg_q.dead_band  <= RST_DEAD_BAND;
			cfg_q.lost_limit <= RST_LOST_LIMIT;
			cfg_q.home_gain  <= RST_HOME_GAIN;
			cfg_q.home_pan   <= RST_HOME_PAN;
			cfg_q.home_tilt  <= RST_HOME_TILT;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_GAIN_P:     cfg_q.gain_p     <= cfg_wdata;
				REG_GAIN_I:     cfg_q.gain_i     <= cfg_wdata;
				REG_GAIN_D:     cfg_q.gain_d     <= cfg_wdata;
				REG_DEAD_BAND:  cfg_q.dead_band  <= cfg_wdata[7:0];
				REG_LOST_LIMIT: cfg_q.lost_limit <= cfg_wdata[15:0];
				REG_HOME_GAIN:  cfg_q.home_gain  <= cfg_wdata[15:0];
				REG_HOME_PAN:   cfg_q.home_pan   <= cfg_wdata;
				REG_HOME_TILT:  cfg_q.home_tilt  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/ptt_mul.sv -----
// Shared signed multiplier with registered product.
module ptt_mul (
	input  logic                                clk,
	input  logic signed [ptt_pkg::PA_W-1:0]     op_a,
	input  logic signed [ptt_pkg::PB_W-1:0]     op_b,
	output logic signed [ptt_pkg::PROD_W-1:0]   prod
);
	import ptt_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

// ----- rtl/pan_tilt_tracking_pid.sv -----
// Pan/tilt tracking controller: sequencer and datapath around one shared multiplier.
//
// One input transfer per camera frame carries the target pixel position
// (target_px, target_py); each yields exactly one output transfer with the
// pan and tilt angles (unsigned Q8.16 degrees) and the tracking mode.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) are registered in ptt_cfg.
// Before the result is ready, a valid position takes eight products through the
// shared multiplier, one issued per cycle, plus two angle updates; returning
// home takes two products and two angle updates, and holding takes no product.
// The next item can be taken in the cycle after the result is loaded into the
// output register.
// A result waiting under out_stall does not block the next item; the block
// then holds its finished result until the output register frees up.
// Reset sets the angles to the home register defaults, clears integrals,
// last errors and the miss counter, and loads the register defaults.
module pan_tilt_tracking_pid #(
	parameter int CENTER_X     = 320,
	parameter int CENTER_Y     = 240,
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] target_px,
	input  logic [15:0] target_py,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] pan_angle,
	output logic [23:0] tilt_angle,
	output logic [1:0]  track_mode,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);
	import ptt_pkg::*;

	function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [17:0] e);
		logic signed [ERR_W-1:0] r;
		if (e < -18'sd1024)
			r = -11'sd1024;
		else if (e > 18'sd1023)
			r = 11'sd1023;
		else
			r = e[ERR_W-1:0];
		return r;
	endfunction

	function automatic logic [ANG_W-1:0] clamp_ang(input logic signed [POS_W-1:0] v);
		logic [ANG_W-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed({10'b0, ANG_MAX}))
			r = ANG_MAX;
		else
			r = v[ANG_W-1:0];
		return r;
	endfunction

	function automatic logic [ERR_W-1:0] mag_err(input logic signed [ERR_W-1:0] e);
		logic [ERR_W:0] w;
		w = e[ERR_W-1] ? -{e[ERR_W-1], e} : {e[ERR_W-1], e};
		return w[ERR_W-1:0];
	endfunction

	cfg_t cfg;

	ptt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	logic signed [PA_W-1:0]   op_a;
	logic signed [PB_W-1:0]   op_b;
	logic signed [PROD_W-1:0] prod;

	ptt_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	state_t state_q, state_d;
	logic [3:0] step_q;

	logic [ANG_W-1:0]        pan_pos_q, tilt_pos_q;
	logic signed [ACC_W-1:0] pan_acc_q, tilt_acc_q;
	logic signed [ERR_W-1:0] pan_prev_q, tilt_prev_q;
	logic [15:0]             miss_q;
	logic signed [ERR_W-1:0] err_x_q, err_y_q;
	logic                    dead_x_q, dead_y_q, flip_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [1:0]              mode_q;

	logic              out_valid_q;
	logic [ANG_W-1:0]  pan_out_q, tilt_out_q;
	logic [1:0]        mode_out_q;

	// Input decode
	logic accept, pos_ok, dead_x, dead_y, home_go, out_free;
	logic signed [ERR_W-1:0] ex, ey;
	logic [8:0]  band_x;
	logic [15:0] miss_next;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign pos_ok = (target_px != 16'hFFFF) && (target_py != 16'hFFFF)
		&& ({1'b0, target_px} <= 17'(FRAME_WIDTH))
		&& ({1'b0, target_py} <= 17'(FRAME_HEIGHT));
	assign ex = sat_err($signed({2'b0, target_px}) - 18'(CENTER_X));
	assign ey = sat_err($signed({2'b0, target_py}) - 18'(CENTER_Y));
	assign band_x = {1'b0, cfg.dead_band} + 9'd3;
	assign dead_x = {1'b0, mag_err(ex)} < {3'b0, band_x};
	assign dead_y = mag_err(ey) < {3'b0, cfg.dead_band};
	assign miss_next = (miss_q == 16'hFFFF) ? miss_q : miss_q + 16'd1;
	assign home_go = miss_next > cfg.lost_limit;

	// Operand selection for the shared multiplier
	logic                    iss_ax;
	logic [1:0]              iss_op;
	logic signed [ERR_W-1:0] iss_err, iss_prev;
	logic signed [ACC_W-1:0] iss_acc;
	logic                    iss_dead;
	logic signed [ERR_W:0]   iss_diff;
	logic signed [PA_W-1:0]  acc_abs;

	assign iss_ax   = step_q[2];
	assign iss_op   = step_q[1:0];
	assign iss_err  = iss_ax ? err_y_q : err_x_q;
	assign iss_prev = iss_ax ? tilt_prev_q : pan_prev_q;
	assign iss_acc  = iss_ax ? tilt_acc_q : pan_acc_q;
	assign iss_dead = iss_ax ? dead_y_q : dead_x_q;
	assign iss_diff = {iss_err[ERR_W-1], iss_err} - {iss_prev[ERR_W-1], iss_prev};
	assign acc_abs  = iss_acc[ACC_W-1] ? -PA_W'(iss_acc) : PA_W'(iss_acc);

	always_comb begin
		op_a = PA_W'(iss_err);
		op_b = K_03;
		if (state_q == ST_HOME) begin
			op_b = {9'b0, cfg.home_gain};
			if (step_q[0])
				op_a = PA_W'($signed({1'b0, cfg.home_tilt}) - $signed({1'b0, tilt_pos_q}));
			else
				op_a = PA_W'($signed({1'b0, cfg.home_pan}) - $signed({1'b0, pan_pos_q}));
		end else begin
			case (iss_op)
				OP_ACC: begin
					if (iss_dead) begin
						op_a = acc_abs;
						op_b = K_09;
					end
				end
				OP_P: begin
					op_b = {1'b0, cfg.gain_p};
				end
				OP_I: begin
					op_a = PA_W'(iss_acc);
					op_b = {1'b0, cfg.gain_i};
				end
				default: begin
					op_a = PA_W'(iss_diff);
					op_b = {1'b0, cfg.gain_d};
				end
			endcase
		end
	end

	// Consume side: product of the previous step
	logic [3:0]              c_step;
	logic                    c_ax, c_dead;
	logic [1:0]              c_op;
	logic signed [ACC_W-1:0] c_acc, acc_new;
	logic signed [PA_W-1:0]  acc_sum;
	logic [ACC_W-1:0]        acc_decay;
	logic signed [SUM_W-1:0] prod_ext;

	assign c_step   = step_q - 4'd1;
	assign c_ax     = c_step[2];
	assign c_op     = c_step[1:0];
	assign c_acc    = c_ax ? tilt_acc_q : pan_acc_q;
	assign c_dead   = c_ax ? dead_y_q : dead_x_q;
	assign prod_ext = SUM_W'(prod);
	assign acc_sum  = PA_W'(c_acc) + prod[PA_W-1:0];
	assign acc_decay = prod[ACC_W+15:16];

	always_comb begin
		if (c_dead)
			acc_new = c_acc[ACC_W-1] ? -$signed(acc_decay) : $signed(acc_decay);
		else if (acc_sum > ACC_LIM)
			acc_new = ACC_LIM[ACC_W-1:0];
		else if (acc_sum < -ACC_LIM)
			acc_new = -ACC_LIM[ACC_W-1:0];
		else
			acc_new = acc_sum[ACC_W-1:0];
	end

	// Angle update from the rounded PID sum
	logic                    u_ax, u_dead;
	logic signed [SUM_W-1:0] sum_rnd;
	logic signed [31:0]      inc;
	logic [ANG_W-1:0]        u_pos, pid_pos_new;

	assign u_ax    = (step_q == 4'd9);
	assign u_dead  = u_ax ? dead_y_q : dead_x_q;
	assign u_pos   = u_ax ? tilt_pos_q : pan_pos_q;
	assign sum_rnd = sum_q + SUM_W'(64'sd8388608);
	always_comb begin
		inc = u_dead ? 32'sd0 : sum_rnd[SUM_W-1:24];
		if (flip_q)
			inc = -inc;
	end
	assign pid_pos_new = clamp_ang(POS_W'($signed({1'b0, u_pos})) + POS_W'(inc));

	// Homing step from the product
	logic signed [PROD_W-1:0] home_rnd;
	logic [ANG_W-1:0]         h_pos, home_pos_new;

	assign h_pos        = step_q[1] ? tilt_pos_q : pan_pos_q;
	assign home_rnd     = prod + PROD_W'(64'sd32768);
	assign home_pos_new = clamp_ang(POS_W'($signed({1'b0, h_pos}))
		+ POS_W'($signed(home_rnd[41:16])));

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (pos_ok)
						state_d = ST_PID;
					else if (home_go)
						state_d = ST_HOME;
					else
						state_d = ST_DONE;
				end
			end
			ST_PID: begin
				if (step_q == 4'd9)
					state_d = ST_DONE;
			end
			ST_HOME: begin
				if (step_q == 4'd2)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			pan_pos_q   <= RST_HOME_PAN;
			tilt_pos_q  <= RST_HOME_TILT;
			pan_acc_q   <= '0;
			tilt_acc_q  <= '0;
			pan_prev_q  <= '0;
			tilt_prev_q <= '0;
			miss_q      <= '0;
			mode_q      <= MODE_TRACK;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE)
				step_q <= '0;
			else
				step_q <= step_q + 4'd1;

			if (accept) begin
				if (pos_ok) begin
					miss_q <= '0;
					mode_q <= MODE_TRACK;
				end else begin
					miss_q <= miss_next;
					if (home_go) begin
						mode_q     <= MODE_HOME;
						pan_acc_q  <= '0;
						tilt_acc_q <= '0;
					end else begin
						mode_q <= MODE_HOLD;
					end
				end
			end

			if (state_q == ST_PID && step_q != 4'd0 && step_q != 4'd9) begin
				if (c_op == OP_ACC) begin
					if (c_ax)
						tilt_acc_q <= acc_new;
					else
						pan_acc_q <= acc_new;
				end
				if (c_op == OP_D) begin
					if (c_ax)
						tilt_prev_q <= dead_y_q ? '0 : err_y_q;
					else
						pan_prev_q <= dead_x_q ? '0 : err_x_q;
				end
			end

			if (state_q == ST_PID && (step_q == 4'd5 || step_q == 4'd9)) begin
				if (u_ax)
					tilt_pos_q <= pid_pos_new;
				else
					pan_pos_q <= pid_pos_new;
			end

			if (state_q == ST_HOME && step_q != 4'd0) begin
				if (step_q[1])
					tilt_pos_q <= home_pos_new;
				else
					pan_pos_q <= home_pos_new;
			end

			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			err_x_q  <= ex;
			err_y_q  <= ey;
			dead_x_q <= dead_x;
			dead_y_q <= dead_y;
			flip_q   <= tilt_pos_q > ANG_FLIP;
		end
		if (state_q == ST_PID && step_q != 4'd0 && step_q != 4'd9) begin
			case (c_op)
				OP_P:    sum_q <= prod_ext <<< 16;
				OP_I:    sum_q <= sum_q + prod_ext;
				OP_D:    sum_q <= sum_q + (prod_ext <<< 16);
				default: ;
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			pan_out_q  <= pan_pos_q;
			tilt_out_q <= tilt_pos_q;
			mode_out_q <= mode_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pan_angle  = pan_out_q;
	assign tilt_angle = tilt_out_q;
	assign track_mode = mode_out_q;

endmodule
